// ===== src/sfp_pkg.sv =====
`default_nettype none

package sfp_pkg;

  // Frame geometry.
  localparam int FrameBytes   = 19;
  localparam int MaxFramesDef = 2;
  localparam int CountWidth   = 6;
  localparam int PosWidth     = 5;

  // Result queue.
  localparam int FifoDepth    = 4;
  localparam int FifoPtrWidth = 2;
  localparam int FifoCntWidth = 3;

  // Register map, as word indexes.
  localparam logic RegHeaderFirst  = 1'b0;
  localparam logic RegHeaderSecond = 1'b1;

  // Message types.
  localparam logic [7:0] TypeStatus = 8'h02;
  localparam logic [7:0] TypeVerify = 8'h09;

  // Speed modes.
  localparam logic [3:0] ModeEco      = 4'd0;
  localparam logic [3:0] ModeNormal   = 4'd1;
  localparam logic [3:0] ModeCruise   = 4'd2;
  localparam logic [3:0] ModeSport    = 4'd3;
  localparam logic [3:0] ModeHike     = 4'd4;
  localparam logic [3:0] ModeAuto     = 4'd5;
  localparam logic [3:0] ModeLaunch   = 4'd6;
  localparam logic [3:0] ModeAntislip = 4'd7;
  localparam logic [3:0] ModeValet    = 4'd8;
  localparam logic [3:0] ModeNone     = 4'd10;

  localparam logic [5:0] StudyBusy = 6'd48;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StBadHeader   = 2'd1,
    StBadChecksum = 2'd2,
    StBadLength   = 2'd3
  } sfp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sfp_in_t;

  typedef struct packed {
    sfp_status_e status;
    logic [7:0]  sequence_res;
    logic [7:0]  frame_type;
    logic [31:0] device_ident;
    logic [3:0]  speed_mode;
    logic [3:0]  step_value;
    logic [3:0]  mode_flags;
    logic [15:0] depth_pair;
    logic [5:0]  study_info;
    logic [7:0]  version_tenths;
    logic [1:0]  notice_code;
    logic        last_result;
  } sfp_res_t;

  // Result for a notification of bad length.
  function automatic sfp_res_t sfp_error_res();
    sfp_res_t r;
    r            = '0;
    r.status     = StBadLength;
    r.speed_mode = ModeNone;
    r.last_result = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/sfp_frame_dec.sv =====
`default_nettype none

module sfp_frame_dec
  import sfp_pkg::*;
(
  input  var logic [7:0]        hdr_first_i,
  input  var logic [7:0]        hdr_second_i,
  input  var logic [17:0][7:0]  frame_i,
  input  var logic [7:0]        chk_byte_i,
  input  var logic [7:0]        sum_i,
  output sfp_res_t              res_o
);

  logic [7:0] b3;
  logic [7:0] b7;
  logic [3:0] hi_nib;

  assign b3     = frame_i[3];
  assign b7     = frame_i[7];
  assign hi_nib = frame_i[10][7:4];

  always_comb begin
    res_o            = '0;
    res_o.status     = StOk;
    res_o.speed_mode = ModeNone;
    if (frame_i[0] != hdr_first_i || frame_i[1] != hdr_second_i) begin
      res_o.status = StBadHeader;
    end else if (sum_i != chk_byte_i) begin
      res_o.status = StBadChecksum;
    end else begin
      res_o.sequence_res = frame_i[2];
      res_o.frame_type   = b3;
      res_o.device_ident = {frame_i[14], frame_i[15], frame_i[16], frame_i[17]};
      res_o.mode_flags[3] = (b3 == TypeVerify) && (frame_i[4] != 8'd0);
      if (b3 == TypeStatus) begin
        res_o.mode_flags[0] = b7[7];
        res_o.mode_flags[1] = b7[4];
        res_o.mode_flags[2] = (frame_i[12] == 8'd0);
        // Low bits of byte 7 override the mode byte.
        priority if (b7[2:0] == 3'd0) begin
          unique case (frame_i[4])
            8'd0: begin
              res_o.speed_mode = ModeEco;
              res_o.step_value = frame_i[5][3:0];
            end
            8'd1: res_o.speed_mode = ModeNormal;
            8'd2: begin
              res_o.speed_mode = ModeCruise;
              res_o.step_value = frame_i[5][7:4];
            end
            8'd3: begin
              res_o.speed_mode = ModeSport;
              res_o.step_value = frame_i[6][3:0];
            end
            8'd4: begin
              res_o.speed_mode = ModeHike;
              res_o.step_value = frame_i[6][7:4];
            end
            8'd5: res_o.speed_mode = ModeAuto;
            default: res_o.speed_mode = ModeNone;
          endcase
        end else if (b7[0]) begin
          res_o.speed_mode = ModeLaunch;
        end else if (b7[1]) begin
          res_o.speed_mode = ModeAntislip;
        end else begin
          res_o.speed_mode = ModeValet;
        end
        res_o.depth_pair = {frame_i[8], frame_i[9]};
        priority if (hi_nib == 4'd1) begin
          res_o.study_info = {2'b01, frame_i[10][3:0]};
        end else if (hi_nib > 4'd1) begin
          res_o.study_info = (frame_i[10][3:0] != 4'd0) ? StudyBusy : 6'd0;
        end else begin
          res_o.study_info = 6'd0;
        end
        res_o.version_tenths = frame_i[11];
        priority if (frame_i[13][2]) begin
          res_o.notice_code = 2'd1;
        end else if (frame_i[13][3]) begin
          res_o.notice_code = 2'd2;
        end else if (frame_i[13][4]) begin
          res_o.notice_code = 2'd3;
        end else begin
          res_o.notice_code = 2'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sfp_res_fifo.sv =====
`default_nettype none

module sfp_res_fifo
  import sfp_pkg::*;
(
  input  var logic     clk_i,
  input  var logic     rst_ni,
  input  var logic     push_a_i,
  input  var sfp_res_t data_a_i,
  input  var logic     push_b_i,
  input  var sfp_res_t data_b_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  var logic     out_ready_i,
  output sfp_res_t     out_data_o
);

  sfp_res_t                mem_q [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FifoCntWidth-1:0] cnt_q, cnt_d;
  logic [FifoPtrWidth-1:0] wr_ptr_b;
  logic                    pop;
  logic [FifoCntWidth-1:0] n_push;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room for the two beats a notification may leave behind.
  assign space_o     = (cnt_q <= FifoCntWidth'(FifoDepth - 2));
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_b    = wr_ptr_q + (push_a_i ? FifoPtrWidth'(1) : '0);
  assign n_push      = FifoCntWidth'(push_a_i) + FifoCntWidth'(push_b_i);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrWidth'(n_push);
    rd_ptr_d = rd_ptr_q + (pop ? FifoPtrWidth'(1) : '0);
    cnt_d    = cnt_q + n_push - (pop ? FifoCntWidth'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_ptr_b] <= data_b_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/status_frame_parser_top.sv =====
// The result beats of a notification are written into the result queue when its last
// byte is accepted; for a two-frame notification both beats are written together.
// Throughput: one byte per cycle. Input stalls only while the four-entry result queue
// holds more than two beats, i.e. when the output side is backpressured.
// Reset clears the byte count, the result queue and both header registers; the
// buffered frame bytes are not reset.
`default_nettype none

module status_frame_parser_top
  import sfp_pkg::*;
#(
  parameter int MAX_FRAMES = MaxFramesDef
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output logic            in_ready_o,
  input  var sfp_in_t     in_data_i,
  output logic            out_valid_o,
  input  var logic        out_ready_i,
  output sfp_res_t        out_data_o,
  input  var logic        psel,
  input  var logic        penable,
  input  var logic        pwrite,
  input  var logic [2:0]  paddr,
  input  var logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int StoreBytes = FrameBytes * MAX_FRAMES;
  localparam logic [CountWidth-1:0] StoreCnt  = CountWidth'(StoreBytes);
  localparam logic [CountWidth-1:0] FrameCnt  = CountWidth'(FrameBytes);
  localparam logic [CountWidth-1:0] DoubleCnt = CountWidth'(2 * FrameBytes);
  localparam logic [PosWidth-1:0]   ChkPos    = PosWidth'(FrameBytes - 1);

  logic [7:0]            hdr_first_q, hdr_second_q;
  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic [PosWidth-1:0]   pos;
  logic [17:0][7:0]      fb_q;
  logic [7:0]            sum_q;
  sfp_res_t              pend_q;
  sfp_res_t              dec_res;
  sfp_res_t              res_a, res_b;
  logic                  accept, store_en, cfg_wr;
  logic                  one_frame, two_frames;
  logic                  push_a, push_b;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      RegHeaderFirst:  prdata = {24'd0, hdr_first_q};
      RegHeaderSecond: prdata = {24'd0, hdr_second_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= '0;
      hdr_second_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegHeaderFirst:  hdr_first_q  <= pwdata[7:0];
        RegHeaderSecond: hdr_second_q <= pwdata[7:0];
        default:         hdr_first_q  <= hdr_first_q;
      endcase
    end
  end

  // Byte collection.
  assign accept   = in_valid_i && in_ready_o;
  assign store_en = accept && (cnt_q < StoreCnt);
  assign pos      = (cnt_q < FrameCnt) ? cnt_q[PosWidth-1:0]
                                       : PosWidth'(cnt_q - FrameCnt);
  // The count saturates one past the store size so that overlong input stays bad.
  assign cnt_inc  = (cnt_q <= StoreCnt) ? cnt_q + CountWidth'(1) : cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = in_data_i.last_byte ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 18; i++) begin
      if (store_en && pos == PosWidth'(i)) begin
        fb_q[i] <= in_data_i.data_byte;
      end
    end
  end

  // Checksum over frame bytes 2 to 17, gathered as they arrive.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      if (pos == '0) begin
        sum_q <= '0;
      end else if (pos >= PosWidth'(2) && pos < ChkPos) begin
        sum_q <= sum_q + in_data_i.data_byte;
      end
    end
  end

  sfp_frame_dec u_dec (
    .hdr_first_i  (hdr_first_q),
    .hdr_second_i (hdr_second_q),
    .frame_i      (fb_q),
    .chk_byte_i   (in_data_i.data_byte),
    .sum_i        (sum_q),
    .res_o        (dec_res)
  );

  // The first frame of a long notification is decoded when its check byte arrives.
  always_ff @(posedge clk_i) begin
    if (accept && cnt_q == FrameCnt - CountWidth'(1)) begin
      pend_q <= dec_res;
    end
  end

  assign one_frame  = (cnt_inc == FrameCnt);
  assign two_frames = (MAX_FRAMES == 2) && (cnt_inc == DoubleCnt);

  always_comb begin
    push_a = accept && in_data_i.last_byte;
    push_b = push_a && two_frames;
    res_b  = dec_res;
    res_b.last_result = 1'b1;
    priority if (two_frames) begin
      res_a = pend_q;
      res_a.last_result = 1'b0;
    end else if (one_frame) begin
      res_a = dec_res;
      res_a.last_result = 1'b1;
    end else begin
      res_a = sfp_error_res();
    end
  end

  sfp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (push_a),
    .data_a_i    (res_a),
    .push_b_i    (push_b),
    .data_b_i    (res_b),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
